### hdl/agkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agkf_pkg
// Shared types, codes, reset values and saturation helpers for the two-state
// angle / gyro bias Kalman filter.
// ----------------------------------------------------------------------------
package agkf_pkg;

    localparam int VAL_W  = 32;   // Q16.16 angle and rate
    localparam int COV_W  = 48;   // Q8.40 covariance and gains
    localparam int CFG_W  = 32;   // Q8.24 configuration
    localparam int OPA_W  = 52;   // multiplier operand a (signed)
    localparam int SUM_W  = 50;   // width of saturating sums
    localparam int IDX_W  = 8;    // configuration index

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_Q_ANGLE = 8'd0;
    localparam logic [IDX_W-1:0] CFG_Q_BIAS  = 8'd1;
    localparam logic [IDX_W-1:0] CFG_R_MEAS  = 8'd2;
    localparam logic [IDX_W-1:0] CFG_DT      = 8'd3;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_Q_ANGLE = 32'd167772;
    localparam logic [CFG_W-1:0] RST_Q_BIAS  = 32'd16777;
    localparam logic [CFG_W-1:0] RST_R_MEAS  = 32'd16777216;
    localparam logic [CFG_W-1:0] RST_DT      = 32'd83886;

    // 1.0 in Q8.40
    localparam logic [COV_W-1:0] COV_ONE = 48'h0100_0000_0000;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LAUNCH,
        SEQ_WAIT,
        SEQ_OUT
    } t_seq_state;

    // bias is corrected before the angle so the innovation sees the predicted angle
    typedef enum logic [3:0] {
        OP_ANGLE_PRED,
        OP_P00_PRED,
        OP_P01_PRED,
        OP_P11_PRED,
        OP_K0,
        OP_K1,
        OP_P11_CORR,
        OP_P10_CORR,
        OP_P01_CORR,
        OP_P00_CORR,
        OP_BIAS_CORR,
        OP_ANGLE_CORR
    } t_op;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_RND,
        MUL_SAT
    } t_mul_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_SAT
    } t_div_state;

    // sh40: scale down by 2^40 (else 2^24); w40: saturate to 40 bits (else 48)
    typedef struct packed {
        logic start;
        logic sh40;
        logic w40;
    } t_mul_req;

    function automatic logic [VAL_W-1:0] f_sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [COV_W-1:0] f_sat48(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = 50'sd140737488355327;
        lo = -50'sd140737488355328;
        if (v > hi) begin
            return 48'h7FFF_FFFF_FFFF;
        end else if (v < lo) begin
            return 48'h8000_0000_0000;
        end
        return v[COV_W-1:0];
    endfunction

endpackage

### hdl/agkf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agkf_in_if
// Sample channel: accelerometer angle and gyro rate, valid / ready.
// ----------------------------------------------------------------------------
interface agkf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;

    modport source (output valid, output measured_angle, output gyro_rate, input ready);
    modport sink   (input valid, input measured_angle, input gyro_rate, output ready);
endinterface

### hdl/agkf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agkf_out_if
// Result channel: filtered angle and bias-corrected rate, valid / ready.
// ----------------------------------------------------------------------------
interface agkf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] filtered_angle;
    logic signed [31:0] corrected_rate;

    modport source (output valid, output filtered_angle, output corrected_rate, input ready);
    modport sink   (input valid, input filtered_angle, input corrected_rate, output ready);
endinterface

### hdl/agkf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agkf_mul
// Bit-serial sign-magnitude multiplier, one bit of b per cycle, followed by
// rounding half away from zero and saturation to 40 or 48 bits.
// ----------------------------------------------------------------------------
module agkf_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  agkf_pkg::t_mul_req  i_req,
    input  logic signed [51:0]  i_a,
    input  logic signed [47:0]  i_b,
    output logic                o_done,
    output logic [47:0]         o_res
);

    agkf_pkg::t_mul_state r_st, n_st;
    logic [5:0]   r_cnt, n_cnt;
    logic [51:0]  r_amag, n_amag;
    logic [47:0]  r_bsr, n_bsr;
    logic [99:0]  r_acc, n_acc;
    logic         r_neg, n_neg;
    logic         r_sh40, n_sh40;
    logic         r_w40, n_w40;
    logic [76:0]  r_q, n_q;
    logic [47:0]  r_res, n_res;
    logic         r_done, n_done;

    logic [52:0]  s_sum;
    logic         s_big;
    logic [47:0]  s_lim;
    logic [47:0]  s_mag;

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_amag = r_amag;
        n_bsr  = r_bsr;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_sh40 = r_sh40;
        n_w40  = r_w40;
        n_q    = r_q;
        n_res  = r_res;
        n_done = 1'b0;
        s_sum  = '0;
        s_big  = 1'b0;
        s_lim  = '0;
        s_mag  = '0;
        unique case (r_st)
            agkf_pkg::MUL_IDLE: begin
                if (i_req.start) begin
                    n_amag = i_a[51] ? 52'(-i_a) : 52'(i_a);
                    n_bsr  = i_b[47] ? 48'(-i_b) : 48'(i_b);
                    n_neg  = i_a[51] ^ i_b[47];
                    n_sh40 = i_req.sh40;
                    n_w40  = i_req.w40;
                    n_acc  = '0;
                    n_cnt  = 6'd47;
                    n_st   = agkf_pkg::MUL_RUN;
                end
            end
            agkf_pkg::MUL_RUN: begin
                // add into the top, shift the finished low bits out to the right
                s_sum = {1'b0, r_acc[99:48]} + (r_bsr[0] ? {1'b0, r_amag} : 53'd0);
                n_acc = {s_sum, r_acc[47:1]};
                n_bsr = r_bsr >> 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_st = agkf_pkg::MUL_RND;
                end
            end
            agkf_pkg::MUL_RND: begin
                // floor of the shift plus the first dropped bit
                n_q = r_sh40 ? ({17'd0, r_acc[99:40]} + 77'(r_acc[39]))
                             : ({1'b0, r_acc[99:24]} + 77'(r_acc[23]));
                n_st = agkf_pkg::MUL_SAT;
            end
            agkf_pkg::MUL_SAT: begin
                s_big  = r_w40 ? (|r_q[76:39]) : (|r_q[76:47]);
                s_lim  = r_w40 ? 48'h0080_0000_0000 : 48'h8000_0000_0000;
                s_mag  = s_big ? (r_neg ? s_lim : s_lim - 48'd1) : r_q[47:0];
                n_res  = r_neg ? 48'(-s_mag) : s_mag;
                n_done = 1'b1;
                n_st   = agkf_pkg::MUL_IDLE;
            end
            default: begin
                n_st = agkf_pkg::MUL_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= agkf_pkg::MUL_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_amag <= n_amag;
        r_bsr  <= n_bsr;
        r_acc  <= n_acc;
        r_neg  <= n_neg;
        r_sh40 <= n_sh40;
        r_w40  <= n_w40;
        r_q    <= n_q;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### hdl/agkf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agkf_div
// Restoring bit-serial divider: num * 2^40 / den, truncated toward zero,
// one quotient bit per cycle, saturated to 48 bits signed.
// ----------------------------------------------------------------------------
module agkf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [47:0]  i_num,
    input  logic signed [49:0]  i_den,
    output logic                o_done,
    output logic [47:0]         o_res
);

    localparam logic [49:0] Q_LIM = 50'd140737488355328;

    agkf_pkg::t_div_state r_st, n_st;
    logic [6:0]   r_cnt, n_cnt;
    logic [87:0]  r_sr, n_sr;
    logic [48:0]  r_d, n_d;
    logic [49:0]  r_rem, n_rem;
    logic [49:0]  r_q, n_q;
    logic         r_ovf, n_ovf;
    logic         r_neg, n_neg;
    logic [47:0]  r_res, n_res;
    logic         r_done, n_done;

    logic [47:0]  s_nmag;
    logic [49:0]  s_dmag;
    logic [49:0]  s_rs;
    logic         s_ge;
    logic         s_big;
    logic [47:0]  s_mag;

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_sr   = r_sr;
        n_d    = r_d;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        n_neg  = r_neg;
        n_res  = r_res;
        n_done = 1'b0;
        s_nmag = i_num[47] ? 48'(-i_num) : 48'(i_num);
        s_dmag = i_den[49] ? 50'(-i_den) : 50'(i_den);
        s_rs   = {r_rem[48:0], r_sr[87]};
        s_ge   = s_rs >= {1'b0, r_d};
        s_big  = 1'b0;
        s_mag  = '0;
        unique case (r_st)
            agkf_pkg::DIV_IDLE: begin
                if (i_start) begin
                    n_sr  = {s_nmag, 40'd0};
                    n_d   = s_dmag[48:0];
                    n_rem = '0;
                    n_q   = '0;
                    n_ovf = 1'b0;
                    n_neg = i_num[47] ^ i_den[49];
                    n_cnt = 7'd87;
                    n_st  = agkf_pkg::DIV_RUN;
                end
            end
            agkf_pkg::DIV_RUN: begin
                n_rem = s_ge ? (s_rs - {1'b0, r_d}) : s_rs;
                n_sr  = r_sr << 1;
                // once past the limit the quotient is frozen and flagged
                if (r_q > Q_LIM) begin
                    n_ovf = 1'b1;
                end else begin
                    n_q = {r_q[48:0], s_ge};
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_st = agkf_pkg::DIV_SAT;
                end
            end
            agkf_pkg::DIV_SAT: begin
                s_big  = r_ovf || (r_q >= Q_LIM);
                s_mag  = s_big ? (r_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)
                               : r_q[47:0];
                n_res  = r_neg ? 48'(-s_mag) : s_mag;
                n_done = 1'b1;
                n_st   = agkf_pkg::DIV_IDLE;
            end
            default: begin
                n_st = agkf_pkg::DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= agkf_pkg::DIV_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_sr  <= n_sr;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_ovf <= n_ovf;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### hdl/angle_gyro_kalman_filter_unit.sv
`timescale 1ns / 1ps
// sequencing: the bit-serial multiplier (48 steps per product, ten products) and the
// bit-serial divider (88 steps per gain, two gains) are used in turn; both divides
// are skipped when R + P00 is zero
// throughput: one request at a time; the next is taken once the sequencer is idle
// reset: synchronous active low, registers to defaults, angle and bias zero,
// covariance identity
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter_unit
// Two-state Kalman filter fusing accelerometer angle and gyro rate, with a
// sequencer driving a shared serial multiplier and a serial divider.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    agkf_in_if.sink     i_in,
    agkf_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    agkf_pkg::t_seq_state r_st, n_st;
    agkf_pkg::t_op        r_op, n_op;

    logic [31:0] r_qa, n_qa;
    logic [31:0] r_qb, n_qb;
    logic [31:0] r_r, n_r;
    logic [31:0] r_dt, n_dt;

    logic [31:0] r_angle, n_angle;
    logic [31:0] r_bias, n_bias;
    logic [47:0] r_p00, n_p00;
    logic [47:0] r_p01, n_p01;
    logic [47:0] r_p10, n_p10;
    logic [47:0] r_p11, n_p11;
    logic [47:0] r_k0, n_k0;
    logic [47:0] r_k1, n_k1;
    logic [31:0] r_meas, n_meas;
    logic [31:0] r_gyro, n_gyro;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_angle, n_out_angle;
    logic [31:0] r_out_rate, n_out_rate;

    logic [51:0] s_gyro_bias;
    logic [51:0] s_d0;
    logic [51:0] s_negp11;
    logic [51:0] s_err;
    logic [49:0] s_den;
    logic        s_den_zero;
    logic        s_is_div;

    agkf_pkg::t_mul_req s_mul_req;
    logic [51:0] s_mul_a;
    logic [47:0] s_mul_b;
    logic        s_mul_done;
    logic [47:0] s_mul_res;
    logic [49:0] s_mul_res50;

    logic        s_div_start;
    logic [47:0] s_div_num;
    logic        s_div_done;
    logic [47:0] s_div_res;

    // operand preparation
    assign s_gyro_bias = {{20{r_gyro[31]}}, r_gyro} - {{20{r_bias[31]}}, r_bias};
    assign s_d0        = {4'd0, r_qa, 16'd0} - {{4{r_p01[47]}}, r_p01}
                         - {{4{r_p10[47]}}, r_p10};
    assign s_negp11    = 52'd0 - {{4{r_p11[47]}}, r_p11};
    assign s_err       = {{20{r_meas[31]}}, r_meas} - {{20{r_angle[31]}}, r_angle};
    assign s_den       = {2'd0, r_r, 16'd0} + {{2{r_p00[47]}}, r_p00};
    assign s_den_zero  = (s_den == 50'd0);
    assign s_is_div    = (r_op == agkf_pkg::OP_K0) || (r_op == agkf_pkg::OP_K1);
    assign s_mul_res50 = {{2{s_mul_res[47]}}, s_mul_res};

    always_comb begin
        s_mul_a        = '0;
        s_mul_b        = '0;
        s_mul_req.sh40 = 1'b0;
        s_mul_req.w40  = 1'b0;
        s_div_num      = r_p00;
        unique case (r_op)
            agkf_pkg::OP_ANGLE_PRED: begin
                s_mul_a       = s_gyro_bias;
                s_mul_b       = {16'd0, r_dt};
                s_mul_req.w40 = 1'b1;
            end
            agkf_pkg::OP_P00_PRED: begin
                s_mul_a = s_d0;
                s_mul_b = {16'd0, r_dt};
            end
            agkf_pkg::OP_P01_PRED: begin
                s_mul_a = s_negp11;
                s_mul_b = {16'd0, r_dt};
            end
            agkf_pkg::OP_P11_PRED: begin
                s_mul_a = {4'd0, r_qb, 16'd0};
                s_mul_b = {16'd0, r_dt};
            end
            agkf_pkg::OP_K0: begin
                s_div_num = r_p00;
            end
            agkf_pkg::OP_K1: begin
                s_div_num = r_p10;
            end
            agkf_pkg::OP_P11_CORR: begin
                s_mul_a        = {{4{r_p01[47]}}, r_p01};
                s_mul_b        = r_k1;
                s_mul_req.sh40 = 1'b1;
            end
            agkf_pkg::OP_P10_CORR: begin
                s_mul_a        = {{4{r_p00[47]}}, r_p00};
                s_mul_b        = r_k1;
                s_mul_req.sh40 = 1'b1;
            end
            agkf_pkg::OP_P01_CORR: begin
                s_mul_a        = {{4{r_p01[47]}}, r_p01};
                s_mul_b        = r_k0;
                s_mul_req.sh40 = 1'b1;
            end
            agkf_pkg::OP_P00_CORR: begin
                s_mul_a        = {{4{r_p00[47]}}, r_p00};
                s_mul_b        = r_k0;
                s_mul_req.sh40 = 1'b1;
            end
            agkf_pkg::OP_ANGLE_CORR: begin
                s_mul_a        = s_err;
                s_mul_b        = r_k0;
                s_mul_req.sh40 = 1'b1;
                s_mul_req.w40  = 1'b1;
            end
            agkf_pkg::OP_BIAS_CORR: begin
                s_mul_a        = s_err;
                s_mul_b        = r_k1;
                s_mul_req.sh40 = 1'b1;
                s_mul_req.w40  = 1'b1;
            end
            default: begin
                s_mul_a = '0;
            end
        endcase
        s_mul_req.start = (r_st == agkf_pkg::SEQ_LAUNCH) && !s_is_div;
        s_div_start     = (r_st == agkf_pkg::SEQ_LAUNCH) && s_is_div && !s_den_zero;
    end

    agkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_mul_req),
        .i_a     (s_mul_a),
        .i_b     (s_mul_b),
        .o_done  (s_mul_done),
        .o_res   (s_mul_res)
    );

    agkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_num   (s_div_num),
        .i_den   (s_den),
        .o_done  (s_div_done),
        .o_res   (s_div_res)
    );

    always_comb begin
        n_st        = r_st;
        n_op        = r_op;
        n_qa        = r_qa;
        n_qb        = r_qb;
        n_r         = r_r;
        n_dt        = r_dt;
        n_angle     = r_angle;
        n_bias      = r_bias;
        n_p00       = r_p00;
        n_p01       = r_p01;
        n_p10       = r_p10;
        n_p11       = r_p11;
        n_k0        = r_k0;
        n_k1        = r_k1;
        n_meas      = r_meas;
        n_gyro      = r_gyro;
        n_out_valid = r_out_valid;
        n_out_angle = r_out_angle;
        n_out_rate  = r_out_rate;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                agkf_pkg::CFG_Q_ANGLE: n_qa = i_cfg_data;
                agkf_pkg::CFG_Q_BIAS:  n_qb = i_cfg_data;
                agkf_pkg::CFG_R_MEAS:  n_r  = i_cfg_data;
                agkf_pkg::CFG_DT:      n_dt = i_cfg_data;
                default: begin
                    n_qa = r_qa;
                end
            endcase
        end

        unique case (r_st)
            agkf_pkg::SEQ_IDLE: begin
                if (i_in.valid) begin
                    n_meas = i_in.measured_angle;
                    n_gyro = i_in.gyro_rate;
                    n_op   = agkf_pkg::OP_ANGLE_PRED;
                    n_st   = agkf_pkg::SEQ_LAUNCH;
                end
            end
            agkf_pkg::SEQ_LAUNCH: begin
                if (s_is_div && s_den_zero) begin
                    // no divide: the gain is zero and the correction does nothing
                    if (r_op == agkf_pkg::OP_K0) begin
                        n_k0 = '0;
                    end else begin
                        n_k1 = '0;
                    end
                    n_op = agkf_pkg::t_op'(r_op + 4'd1);
                end else begin
                    n_st = agkf_pkg::SEQ_WAIT;
                end
            end
            agkf_pkg::SEQ_WAIT: begin
                if ((s_is_div && s_div_done) || (!s_is_div && s_mul_done)) begin
                    unique case (r_op)
                        agkf_pkg::OP_ANGLE_PRED:
                            n_angle = agkf_pkg::f_sat32({{18{r_angle[31]}}, r_angle}
                                                        + s_mul_res50);
                        agkf_pkg::OP_P00_PRED:
                            n_p00 = agkf_pkg::f_sat48({{2{r_p00[47]}}, r_p00} + s_mul_res50);
                        agkf_pkg::OP_P01_PRED: begin
                            n_p01 = agkf_pkg::f_sat48({{2{r_p01[47]}}, r_p01} + s_mul_res50);
                            n_p10 = agkf_pkg::f_sat48({{2{r_p10[47]}}, r_p10} + s_mul_res50);
                        end
                        agkf_pkg::OP_P11_PRED:
                            n_p11 = agkf_pkg::f_sat48({{2{r_p11[47]}}, r_p11} + s_mul_res50);
                        agkf_pkg::OP_K0:
                            n_k0 = s_div_res;
                        agkf_pkg::OP_K1:
                            n_k1 = s_div_res;
                        agkf_pkg::OP_P11_CORR:
                            n_p11 = agkf_pkg::f_sat48({{2{r_p11[47]}}, r_p11} - s_mul_res50);
                        agkf_pkg::OP_P10_CORR:
                            n_p10 = agkf_pkg::f_sat48({{2{r_p10[47]}}, r_p10} - s_mul_res50);
                        agkf_pkg::OP_P01_CORR:
                            n_p01 = agkf_pkg::f_sat48({{2{r_p01[47]}}, r_p01} - s_mul_res50);
                        agkf_pkg::OP_P00_CORR:
                            n_p00 = agkf_pkg::f_sat48({{2{r_p00[47]}}, r_p00} - s_mul_res50);
                        agkf_pkg::OP_ANGLE_CORR:
                            n_angle = agkf_pkg::f_sat32({{18{r_angle[31]}}, r_angle}
                                                        + s_mul_res50);
                        agkf_pkg::OP_BIAS_CORR:
                            n_bias = agkf_pkg::f_sat32({{18{r_bias[31]}}, r_bias}
                                                       + s_mul_res50);
                        default: begin
                            n_angle = r_angle;
                        end
                    endcase
                    if (r_op == agkf_pkg::OP_ANGLE_CORR) begin
                        n_st = agkf_pkg::SEQ_OUT;
                    end else begin
                        n_op = agkf_pkg::t_op'(r_op + 4'd1);
                        n_st = agkf_pkg::SEQ_LAUNCH;
                    end
                end
            end
            agkf_pkg::SEQ_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_angle = r_angle;
                    n_out_rate  = agkf_pkg::f_sat32({{18{r_gyro[31]}}, r_gyro}
                                                    - {{18{r_bias[31]}}, r_bias});
                    n_st        = agkf_pkg::SEQ_IDLE;
                end
            end
            default: begin
                n_st = agkf_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= agkf_pkg::SEQ_IDLE;
            r_op        <= agkf_pkg::OP_ANGLE_PRED;
            r_qa        <= agkf_pkg::RST_Q_ANGLE;
            r_qb        <= agkf_pkg::RST_Q_BIAS;
            r_r         <= agkf_pkg::RST_R_MEAS;
            r_dt        <= agkf_pkg::RST_DT;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= agkf_pkg::COV_ONE;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= agkf_pkg::COV_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_op        <= n_op;
            r_qa        <= n_qa;
            r_qb        <= n_qb;
            r_r         <= n_r;
            r_dt        <= n_dt;
            r_angle     <= n_angle;
            r_bias      <= n_bias;
            r_p00       <= n_p00;
            r_p01       <= n_p01;
            r_p10       <= n_p10;
            r_p11       <= n_p11;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k0        <= n_k0;
        r_k1        <= n_k1;
        r_meas      <= n_meas;
        r_gyro      <= n_gyro;
        r_out_angle <= n_out_angle;
        r_out_rate  <= n_out_rate;
    end

    assign i_in.ready           = (r_st == agkf_pkg::SEQ_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_angle = r_out_angle;
    assign o_out.corrected_rate = r_out_rate;

endmodule

### bench/angle_gyro_kalman_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter_unit_tb
// Drives sample requests into the angle / gyro Kalman filter with random gaps
// and result stalls, predicts every filtered angle and corrected rate with a
// bit-exact fixed-point filter model and compares them in order.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter_unit_tb;

    typedef struct packed {
        logic signed [31:0] meas;
        logic signed [31:0] gyro;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } t_est;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    agkf_in_if  in_ch();
    agkf_out_if out_ch();

    angle_gyro_kalman_filter_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // filter model state
    logic [31:0] m_qa, m_qb, m_r, m_dt;
    longint m_angle, m_bias;
    longint m_p[4];

    t_sample pending_q[$];
    t_est    est_q[$];
    int      errors;
    int      hold_off;
    bit      long_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // round(a*b / 2^sh) half away from zero, saturated to w bits
    function automatic longint scale_mul(longint a, longint b, int sh, int w);
        logic [127:0] x, y, p, q;
        logic [127:0] lim;
        bit neg;
        neg = (a < 0) != (b < 0);
        x = (a < 0) ? 128'(-a) : 128'(a);
        y = (b < 0) ? 128'(-b) : 128'(b);
        p = x * y + (128'd1 << (sh - 1));
        q = p >> sh;
        lim = 128'd1 << (w - 1);
        if (neg) begin
            if (q >= lim) return -longint'(lim - 1) - 1;
            return -longint'(q);
        end
        if (q > lim - 1) return longint'(lim - 1);
        return longint'(q);
    endfunction

    function automatic longint gain_div(longint num, longint den);
        logic [127:0] n, d, q;
        logic [127:0] lim;
        n = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        q = (n << 40) / d;
        lim = 128'd1 << 47;
        if ((num < 0) != (den < 0)) begin
            if (q >= lim) return -longint'(lim - 1) - 1;
            return -longint'(q);
        end
        if (q > lim - 1) return longint'(lim - 1);
        return longint'(q);
    endfunction

    task automatic filter_reset();
        m_qa = agkf_pkg::RST_Q_ANGLE; m_qb = agkf_pkg::RST_Q_BIAS;
        m_r = agkf_pkg::RST_R_MEAS; m_dt = agkf_pkg::RST_DT;
        m_angle = 0; m_bias = 0;
        m_p[0] = 64'sd1 <<< 40; m_p[1] = 0; m_p[2] = 0; m_p[3] = 64'sd1 <<< 40;
    endtask

    function automatic t_est filter_step(t_sample s);
        longint meas, gyro, dt, qa, qb, r, p00, p01, p10, p11, d0, d1, err, den;
        longint k0, k1, t0, t1;
        t_est e;
        meas = s.meas; gyro = s.gyro; dt = m_dt;
        qa = longint'(m_qa) <<< 16; qb = longint'(m_qb) <<< 16;
        r = longint'(m_r) <<< 16;
        p00 = m_p[0]; p01 = m_p[1]; p10 = m_p[2]; p11 = m_p[3];
        m_angle = clamp(m_angle + scale_mul(gyro - m_bias, dt, 24, 40), 32);
        d0 = qa - p01 - p10;
        d1 = -p11;
        p00 = clamp(p00 + scale_mul(d0, dt, 24, 48), 48);
        p01 = clamp(p01 + scale_mul(d1, dt, 24, 48), 48);
        p10 = clamp(p10 + scale_mul(d1, dt, 24, 48), 48);
        p11 = clamp(p11 + scale_mul(qb, dt, 24, 48), 48);
        err = meas - m_angle;
        den = r + p00;
        k0 = 0; k1 = 0;
        if (den != 0) begin
            k0 = gain_div(p00, den);
            k1 = gain_div(p10, den);
        end
        t0 = p00; t1 = p01;
        m_p[0] = clamp(p00 - scale_mul(k0, t0, 40, 48), 48);
        m_p[1] = clamp(p01 - scale_mul(k0, t1, 40, 48), 48);
        m_p[2] = clamp(p10 - scale_mul(k1, t0, 40, 48), 48);
        m_p[3] = clamp(p11 - scale_mul(k1, t1, 40, 48), 48);
        m_angle = clamp(m_angle + scale_mul(err, k0, 40, 40), 32);
        m_bias = clamp(m_bias + scale_mul(err, k1, 40, 40), 32);
        e.angle = 32'(m_angle);
        e.rate = 32'(clamp(gyro - m_bias, 32));
        return e;
    endfunction

    // driver: gap drawn per request
    int send_gap;
    bit sent;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = $urandom_range(0, 19);
            sent = 1'b0;
        end else if (in_ch.valid && !sent) begin
            // request still waiting for ready
        end else begin
            sent = 1'b0;
            if (send_gap > 0 || pending_q.size() == 0) begin
                if (send_gap > 0) send_gap--;
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid <= 1'b1;
                in_ch.measured_angle <= pending_q[0].meas;
                in_ch.gyro_rate <= pending_q[0].gyro;
            end
        end
    end

    // acceptance, prediction, checking
    t_sample acc;
    t_est got, want;
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            acc = pending_q.pop_front();
            est_q.push_back(filter_step(acc));
            send_gap = $urandom_range(0, 19);
            sent = 1'b1;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.angle = out_ch.filtered_angle;
            got.rate = out_ch.corrected_rate;
            if (est_q.size() == 0) begin
                $error("unexpected result angle %0d rate %0d", got.angle, got.rate);
                errors++;
            end else begin
                want = est_q.pop_front();
                if (got.angle !== want.angle) begin
                    $error("filtered_angle expected %0d actual %0d", want.angle, got.angle);
                    errors++;
                end
                if (got.rate !== want.rate) begin
                    $error("corrected_rate expected %0d actual %0d", want.rate, got.rate);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    int stall;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall = 0;
        end else if (hold_off > 0) begin
            hold_off--;
            out_ch.ready <= 1'b0;
        end else if (out_ch.valid && out_ch.ready) begin
            stall = $urandom_range(0, 19);
            out_ch.ready <= (stall == 0);
        end else if (stall > 0) begin
            stall--;
            out_ch.ready <= (stall == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic t_sample rand_sample(int mode);
        t_sample s;
        int a;
        a = $urandom_range(-90 * 65536, 90 * 65536);
        case (mode)
            0: begin
                s.meas = $urandom;
                s.gyro = $urandom;
            end
            1: begin
                s.meas = a;
                s.gyro = $urandom_range(0, 2000 * 65536) - 1000 * 65536;
            end
            default: begin
                s.meas = a + $urandom_range(0, 65536 * 4) - 65536 * 2;
                s.gyro = $urandom_range(0, 65536 * 20) - 65536 * 10;
            end
        endcase
        return s;
    endfunction

    task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == agkf_pkg::CFG_Q_ANGLE) m_qa = val;
        else if (idx == agkf_pkg::CFG_Q_BIAS) m_qb = val;
        else if (idx == agkf_pkg::CFG_R_MEAS) m_r = val;
        else if (idx == agkf_pkg::CFG_DT) m_dt = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && est_q.size() == 0);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic push(logic [31:0] m, logic [31:0] g);
        t_sample s;
        s.meas = m;
        s.gyro = g;
        pending_q.push_back(s);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) pending_q.push_back(rand_sample($urandom_range(0, 4)));
    endtask

    initial begin
        errors = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.measured_angle = '0;
        in_ch.gyro_rate = '0;
        out_ch.ready = 1'b0;
        filter_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes with default tuning
        push(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push(32'h8000_0000, 32'h8000_0000);
        push(32'h8000_0000, 32'h7FFF_FFFF);
        push(32'h7FFF_FFFF, 32'h8000_0000);
        push(0, 0);
        push(32'hFFFF_FFFF, 1);
        push(45 << 16, 10 << 16);
        push(-(30 << 16), -(5 << 16));
        drain();

        // zero measurement noise, ignored indexes, large time step, then large measurement noise
        cfg_write(agkf_pkg::CFG_R_MEAS, 0);
        cfg_write(8'd4, 32'hDEAD_BEEF);
        cfg_write(8'hFF, 32'h1234_5678);
        push(10 << 16, 1 << 16);
        push(32'h7FFF_FFFF, 32'h8000_0000);
        push(0, 32'h7FFF_FFFF);
        drain();
        cfg_write(agkf_pkg::CFG_DT, 32'hFFFF_FFFF);
        cfg_write(agkf_pkg::CFG_Q_ANGLE, 32'hFFFF_FFFF);
        cfg_write(agkf_pkg::CFG_Q_BIAS, 32'hFFFF_FFFF);
        push(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push(32'h8000_0000, 32'h8000_0000);
        push(1, 32'hFFFF_FFFF);
        push(0, 0);
        drain();
        cfg_write(agkf_pkg::CFG_R_MEAS, 32'hFFFF_FFFF);
        cfg_write(agkf_pkg::CFG_DT, 1);
        cfg_write(agkf_pkg::CFG_Q_ANGLE, 1);
        cfg_write(agkf_pkg::CFG_Q_BIAS, 0);
        push(5 << 16, 2 << 16);
        push(32'h8000_0000, 32'h7FFF_FFFF);
        push(32'h7FFF_FFFF, 0);
        drain();

        // random, default tuning, with a long receiver hold-off
        cfg_write(agkf_pkg::CFG_Q_ANGLE, agkf_pkg::RST_Q_ANGLE);
        cfg_write(agkf_pkg::CFG_Q_BIAS, agkf_pkg::RST_Q_BIAS);
        cfg_write(agkf_pkg::CFG_R_MEAS, agkf_pkg::RST_R_MEAS);
        cfg_write(agkf_pkg::CFG_DT, agkf_pkg::RST_DT);
        @(negedge i_clk);
        hold_off = 3000;
        run_random(300);
        drain();

        // random tuning phases
        for (int ph = 0; ph < 3; ph++) begin
            cfg_write(agkf_pkg::CFG_Q_ANGLE, $urandom_range(1, 32'h0200_0000));
            cfg_write(agkf_pkg::CFG_Q_BIAS, $urandom_range(0, 32'h0020_0000));
            cfg_write(agkf_pkg::CFG_R_MEAS, $urandom_range(1, 32'h0400_0000));
            cfg_write(agkf_pkg::CFG_DT, $urandom_range(1, 32'h0100_0000));
            run_random(230);
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
